// ----- hw/rtl/oxavg_pkg.sv -----
package oxavg_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W   = 8;
    localparam int IN_W     = 3 * BYTE_W;
    localparam int OUT_W    = 16;
    localparam int WIN_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W    = 8;

    // Store depth and the widths that follow from it.
    localparam int MAX_WINDOW = 16;
    localparam int SAMPLE_W   = 13;
    localparam int SUM_W      = SAMPLE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Reading in hundredths (at most 28305) and the Q0.16 key (at most 16712).
    localparam int READ_W  = 15;
    localparam int KEY_W   = 15;
    localparam int FRAC_W  = 16;
    localparam int CNT_W   = $clog2(SUM_W + READ_W + 1);

    // Calibration constants.
    localparam logic [KEY_W-1:0] KEY_DEFAULT = KEY_W'(11414);
    localparam int KEY_ROUND   = 500;

    // Divide by 1000 as a multiply by ceil(2^34 / 1000) and a shift. The
    // error term stays below one for every numerator under 2^24.
    localparam int KEY_RECIP_W     = 25;
    localparam int KEY_RECIP_SHIFT = 34;
    localparam logic [KEY_RECIP_W-1:0] KEY_RECIP = KEY_RECIP_W'(17179870);
    localparam int KEY_PROD_W      = BYTE_W + FRAC_W + 1 + KEY_RECIP_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_CODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

    // Calibration key: code/1000 in Q0.16 rounded half up, or the default key.
    function automatic logic [KEY_W-1:0] key_q16(input logic [BYTE_W-1:0] code);
        logic [BYTE_W+FRAC_W:0] num;
        logic [KEY_PROD_W-1:0]  prod;
        begin
            num = {1'b0, code, {FRAC_W{1'b0}}} + (BYTE_W + FRAC_W + 1)'(KEY_ROUND);
            prod = KEY_PROD_W'(num) * KEY_PROD_W'(KEY_RECIP);
            if (code == '0)
            begin
                return KEY_DEFAULT;
            end
            return KEY_W'(prod >> KEY_RECIP_SHIFT);
        end
    endfunction

endpackage

// ----- hw/rtl/oxygen_reading_moving_average.sv -----
// Oxygen reading moving average.
//
// Input stream s_axis carries the three reading bytes of one sensor poll. The
// block forms the reading in hundredths of a percent, scales it by the
// calibration key and pushes the sample into a store of recent samples. Each
// input transaction yields one output transaction on m_axis: the truncated
// mean of the filled entries and an error flag when the window is zero.
// The cfg channel writes the key code (index 0) and the window (index 1);
// it is always ready; write it only while the block is idle, a rule that
// the block does not enforce. A window write restarts the fill count and sum.
//
// Steps: READ_W multiply steps (one reading bit a cycle), one update step,
// SUM_W divide steps (one quotient bit a cycle) and one output step; a zero
// window goes straight to the output step. One item is in work at a time and
// the input opens in the cycle after the result is loaded.
// Reset clears the fill count, the sum, the handshake state and loads the
// default key code and a window of 16. When m_axis stalls, the result waits
// in the output register; the next item may be taken meanwhile and holds in
// its last step until the register frees up.
module oxygen_reading_moving_average
    import oxavg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // whole_part [7:0], tenths_part [15:8], hundredths_part [23:16]
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // average_concentration [12:0], zero fill above
    output logic [OUT_W-1:0]     m_axis_tdata,
    // window_error [0]
    output logic                 m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [BYTE_W-1:0]     key_code_reg;
    logic [WIN_W-1:0]      window_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W:0]        prod_hi_reg;
    logic [READ_W-1:0]     prod_lo_reg;
    logic [SUM_W-1:0]      quot_reg;
    logic [FILL_W-1:0]     rem_reg;
    logic                  err_reg;
    logic [SAMPLE_W-1:0]   store_reg [MAX_WINDOW];

    logic                  in_fire;
    logic                  cfg_fire;
    logic                  out_free;
    logic [FILL_W-1:0]     eff_win;
    logic [IDX_W-1:0]      last_idx;
    logic [READ_W-1:0]     reading;
    logic [KEY_W:0]        mul_add;
    logic [SAMPLE_W-1:0]   sample;
    logic                  window_full;
    logic [SAMPLE_W-1:0]   drop_value;
    logic [SUM_W-1:0]      sum_next;
    logic [FILL_W-1:0]     fill_next;
    logic [FILL_W:0]       div_trial;
    logic                  div_bit;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Effective window saturates at the store depth.
    always_comb
    begin
        if (int'(window_reg) > MAX_WINDOW)
        begin
            eff_win = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = FILL_W'(window_reg);
        end
    end

    assign last_idx = IDX_W'(eff_win - FILL_W'(1));

    // Reading in hundredths from the three bytes.
    assign reading = READ_W'(s_axis_tdata[BYTE_W-1:0]) * READ_W'(100)
                   + READ_W'(s_axis_tdata[2*BYTE_W-1:BYTE_W]) * READ_W'(10)
                   + READ_W'(s_axis_tdata[3*BYTE_W-1:2*BYTE_W]);

    // One shift-add step of the serial multiplier, one reading bit per cycle.
    assign mul_add = prod_hi_reg + (prod_lo_reg[0] ? {1'b0, key_reg} : '0);

    // Sample is the product shifted down by the key's fraction bits.
    assign sample = SAMPLE_W'({prod_hi_reg, prod_lo_reg} >> FRAC_W);

    // Running sum and fill count after this sample enters the window.
    assign window_full = (fill_reg >= eff_win);
    assign drop_value  = window_full ? store_reg[last_idx] : '0;
    assign sum_next    = sum_reg - SUM_W'(drop_value) + SUM_W'(sample);
    assign fill_next   = window_full ? eff_win : fill_reg + FILL_W'(1);

    // One restoring divide step, one quotient bit per cycle.
    assign div_trial = {rem_reg, quot_reg[SUM_W-1]};
    assign div_bit   = (div_trial >= {1'b0, fill_reg});

    // Control, arithmetic and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_code_reg  <= '0;
            window_reg    <= WINDOW_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            // A result taken while no new one is loaded empties the register.
            if (m_axis_tvalid && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_axis_tvalid <= 1'b0;
            end

            // Configuration writes; indexes beyond the list are dropped.
            if (cfg_fire)
            begin
                if (cfg_index == REG_KEY_CODE)
                begin
                    key_code_reg <= cfg_data;
                end
                else if (cfg_index == REG_WINDOW)
                begin
                    window_reg <= WIN_W'(cfg_data);
                    fill_reg   <= '0;
                    sum_reg    <= '0;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        cnt_reg     <= '0;
                        key_reg     <= key_q16(key_code_reg);
                        prod_hi_reg <= '0;
                        prod_lo_reg <= reading;
                        quot_reg    <= '0;
                        err_reg     <= (eff_win == '0);
                        state_reg   <= (eff_win == '0) ? ST_OUT : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    {prod_hi_reg, prod_lo_reg} <= {mul_add, prod_lo_reg} >> 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(READ_W - 1))
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    sum_reg   <= sum_next;
                    fill_reg  <= fill_next;
                    quot_reg  <= sum_next;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= div_bit ? FILL_W'(div_trial - {1'b0, fill_reg})
                                        : FILL_W'(div_trial);
                    quot_reg <= {quot_reg[SUM_W-2:0], div_bit};
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= OUT_W'(quot_reg[SAMPLE_W-1:0]);
                        m_axis_tuser  <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sample store: newest in entry 0, entries inside the window move up.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPD)
        begin
            store_reg[0] <= sample;
            for (int k = 1; k < MAX_WINDOW; k++)
            begin
                if (k < int'(eff_win))
                begin
                    store_reg[k] <= store_reg[k-1];
                end
            end
        end
    end

    // The fill count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_WINDOW)
        else $error("fill count beyond store depth");

    // An empty window holds no sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero with empty window");

    // An error result always carries a zero average.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero average");

    // An accepted item blocks further input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_free) |=> (state_reg == ST_OUT))
        else $error("result dropped under a stalled output");

endmodule

// ----- tb/oxavg_checker.sv -----
`timescale 1ns / 1ps

// Watches the reading, result and register channels of the moving average.
// It keeps its own copy of the sample store, running sum and fill count,
// works out the average for every accepted reading and compares each result
// transaction with the oldest pending one.
module oxavg_checker
    import oxavg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    // Key used when the calibration byte is zero: 20.9/120 in Q0.16.
    localparam int unsigned DEFAULT_KEY_Q16 = 11414;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                window_error;
    } average_t;

    logic [CFG_W-1:0] key_code_q;
    logic [WIN_W-1:0] window_q;
    int unsigned      sample_mem [MAX_WINDOW];
    int unsigned      sum_q;
    int unsigned      count_q;
    average_t         pending_averages [$];

    // Pushes one reading into the predicted store and returns the new average.
    function automatic average_t push_reading(input logic [BYTE_W-1:0] whole,
                                              input logic [BYTE_W-1:0] tenths,
                                              input logic [BYTE_W-1:0] hund);
        int unsigned win;
        int unsigned reading;
        int unsigned key;
        int unsigned sample;
        int          k;
        average_t    res;
        begin
            res = '0;
            win = (32'(window_q) > MAX_WINDOW) ? MAX_WINDOW : 32'(window_q);
            // A zero window flags an error and leaves the store alone.
            if (win == 0)
            begin
                res.window_error = 1'b1;
                return res;
            end
            reading = 32'(whole) * 100 + 32'(tenths) * 10 + 32'(hund);
            key = 32'(key_code_q);
            key = (key == 0) ? DEFAULT_KEY_Q16 : (key * 65536 + 500) / 1000;
            sample = ((reading * key) >> 16) & 32'h1FFF;
            // Once the window is full, the oldest counted entry leaves the sum.
            if (count_q >= win)
            begin
                sum_q = sum_q - sample_mem[win - 1];
                count_q = win;
            end
            else
            begin
                count_q = count_q + 1;
            end
            for (k = win - 1; k > 0; k--)
            begin
                sample_mem[k] = sample_mem[k - 1];
            end
            sample_mem[0] = sample;
            sum_q = sum_q + sample;
            res.average = SAMPLE_W'(sum_q / count_q);
            return res;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        average_t want;
        int       errs;
        int       pushed;
        int       popped;
        if (!rst_n)
        begin
            key_code_q = '0;
            window_q = WIN_W'(MAX_WINDOW);
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                sample_mem[k] = 0;
            end
            sum_q = 0;
            count_q = 0;
            pending_averages.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            pushed = 0;
            popped = 0;
            // Result transaction: compare with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_averages.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got average %0d error %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    errs++;
                end
                else
                begin
                    want = pending_averages.pop_front();
                    popped = 1;
                    if (m_axis_tdata !== OUT_W'(want.average))
                    begin
                        $display("%0t: average mismatch, expected %0d, got %0d",
                                 $time, want.average, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tuser !== want.window_error)
                    begin
                        $display("%0t: window error mismatch, expected %0d, got %0d",
                                 $time, want.window_error, m_axis_tuser);
                        errs++;
                    end
                end
            end
            // Register write; a window write restarts the fill count and sum.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_KEY_CODE)
                begin
                    key_code_q = cfg_data;
                end
                else if (cfg_index == REG_WINDOW)
                begin
                    window_q = cfg_data[WIN_W-1:0];
                    count_q = 0;
                    sum_q = 0;
                end
            end
            // Reading transaction: predict its result.
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_averages.push_back(push_reading(s_axis_tdata[7:0],
                                                        s_axis_tdata[15:8],
                                                        s_axis_tdata[23:16]));
                pushed = 1;
            end
            mismatches <= mismatches + errs;
            outstanding <= outstanding + pushed - popped;
        end
    end

endmodule

// ----- tb/tb_oxygen_reading_moving_average.sv -----
`timescale 1ns / 1ps

module tb_oxygen_reading_moving_average
    import oxavg_pkg::*;
();

    localparam int ITEM_TARGET = 1100;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int SETTLE_CYCLES = 40;

    // Indexes outside the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] NO_REG_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] NO_REG_HIGH = CFG_IDX_W'(255);

    logic                 clk = 1'b0;
    logic                 rst_n;
    // whole_part [7:0], tenths_part [15:8], hundredths_part [23:16]
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // average_concentration [12:0], zero fill above
    logic [OUT_W-1:0]     m_axis_tdata;
    // window_error [0]
    logic                 m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic                 steady = 1'b0;
    logic [WIN_W-1:0]     window_now;
    int                   mismatches;
    int                   outstanding;

    oxygen_reading_moving_average dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    oxavg_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side stalls now and then, except during the steady stretch.
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Holds a register write until its transaction completes; valid is
    // left high so that back-to-back writes never drop it in between.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            if (idx == REG_WINDOW)
            begin
                window_now = data[WIN_W-1:0];
            end
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic send_reading(input logic [BYTE_W-1:0] whole,
                                input logic [BYTE_W-1:0] tenths,
                                input logic [BYTE_W-1:0] hund);
        begin
            // Any register write ahead of this reading has completed.
            cfg_valid <= 1'b0;
            if (!steady)
            begin
                while ($urandom_range(0, 99) < 7)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {hund, tenths, whole};
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic send_random_reading();
        logic [BYTE_W-1:0] whole;
        logic [BYTE_W-1:0] tenths;
        logic [BYTE_W-1:0] hund;
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    whole = BYTE_W'($urandom_range(0, 255));
                    tenths = BYTE_W'($urandom_range(0, 255));
                    hund = BYTE_W'($urandom_range(0, 255));
                end
                2:
                begin
                    // Readings as the sensor would normally report them.
                    whole = BYTE_W'($urandom_range(15, 25));
                    tenths = BYTE_W'($urandom_range(0, 9));
                    hund = BYTE_W'($urandom_range(0, 9));
                end
                default:
                begin
                    whole = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    tenths = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    hund = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            endcase
            send_reading(whole, tenths, hund);
        end
    endtask

    // Waits until every predicted result has been taken.
    task automatic drain_results();
        begin
            s_axis_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (outstanding != 0);
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return CFG_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd2;
            3: return 8'd15;
            4: return 8'd16;
            5: return 8'd17;
            6: return 8'd31;
            default: return CFG_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        window_now = WIN_W'(MAX_WINDOW);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: default key, full window; field extremes.
        send_reading(8'd0, 8'd0, 8'd0);
        send_reading(8'd255, 8'd255, 8'd255);
        send_reading(8'd20, 8'd9, 8'd0);
        send_reading(8'd255, 8'd0, 8'd0);
        send_reading(8'd0, 8'd255, 8'd0);
        send_reading(8'd0, 8'd0, 8'd255);

        // Largest key with a one-entry window.
        drain_results();
        cfg_write(REG_KEY_CODE, 8'd255);
        cfg_write(REG_WINDOW, 8'd1);
        send_reading(8'd255, 8'd255, 8'd255);
        send_reading(8'd100, 8'd0, 8'd0);
        send_reading(8'd0, 8'd0, 8'd1);

        // Zero window flags an error.
        drain_results();
        cfg_write(REG_WINDOW, 8'd0);
        cfg_write(REG_KEY_CODE, 8'd1);
        send_reading(8'd255, 8'd255, 8'd255);
        send_reading(8'd20, 8'd9, 8'd0);

        // Window above the store depth saturates; unknown indexes are ignored.
        drain_results();
        cfg_write(REG_WINDOW, 8'd31);
        cfg_write(NO_REG_LOW, 8'd0);
        cfg_write(NO_REG_HIGH, 8'd0);
        cfg_write(REG_KEY_CODE, 8'd0);
        send_reading(8'd20, 8'd9, 8'd0);
        send_reading(8'd255, 8'd255, 8'd255);
        send_reading(8'd0, 8'd0, 8'd0);
        send_reading(8'd99, 8'd9, 8'd9);

        // A key change alone keeps the fill count running.
        drain_results();
        cfg_write(REG_KEY_CODE, 8'd200);
        send_reading(8'd21, 8'd0, 8'd5);
        send_reading(8'd255, 8'd255, 8'd255);
        send_reading(8'd1, 8'd2, 8'd3);

        // Random phases, each with its own register settings.
        sent = 0;
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            drain_results();
            steady <= (phase >= 10 && phase < 14);
            case ($urandom_range(0, 4))
                0: cfg_write(REG_KEY_CODE, pick_key());
                1: cfg_write(REG_WINDOW, pick_window());
                2:
                begin
                    cfg_write(REG_KEY_CODE, pick_key());
                    cfg_write(REG_WINDOW, pick_window());
                end
                3:
                begin
                    cfg_write(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom()));
                    cfg_write(REG_KEY_CODE, pick_key());
                end
                default:
                begin
                end
            endcase
            n = (window_now == '0) ? $urandom_range(1, 4) : $urandom_range(8, 60);
            repeat (n)
            begin
                send_random_reading();
            end
            sent += n;
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
